// ----- rtl/cdq_pkg.sv -----
package cdq_pkg;

  localparam int unsigned DepthDefault = 16;

  localparam int unsigned FuncWidth   = 3;
  localparam int unsigned ByteWidth   = 8;
  localparam int unsigned StatusWidth = 2;

  typedef enum logic [FuncWidth-1:0] {
    FUNC_PUSH_REAR  = 3'd0,
    FUNC_PUSH_FRONT = 3'd1,
    FUNC_POP_FRONT  = 3'd2,
    FUNC_POP_REAR   = 3'd3,
    FUNC_PEEK_FRONT = 3'd4,
    FUNC_PEEK_REAR  = 3'd5
  } cdq_func_e;

  typedef enum logic [StatusWidth-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } cdq_status_e;

  // Broadcast to every cell of the chain; at most one op bit is set.
  typedef struct packed {
    logic                 push_front;
    logic                 pop_front;
    logic                 push_rear;
    logic                 pop_rear;
    logic [ByteWidth-1:0] value;
  } cdq_cell_cmd_t;

endpackage

// ----- rtl/cdq_if.sv -----
interface cdq_req_if;
  logic                             valid;
  logic                             ready;
  logic [cdq_pkg::FuncWidth-1:0]    func;
  logic [cdq_pkg::ByteWidth-1:0]    value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

interface cdq_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [cdq_pkg::ByteWidth-1:0]    data_out;
  logic [cdq_pkg::StatusWidth-1:0]  status;
  logic                             now_empty;
  logic                             now_full;

  modport source (output valid, output data_out, output status, output now_empty,
                  output now_full, input ready);
  modport sink   (input valid, input data_out, input status, input now_empty,
                  input now_full, output ready);
endinterface

// ----- rtl/cdq_cell.sv -----
module cdq_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cdq_pkg::cdq_cell_cmd_t        cmd_i,
  input  logic [cdq_pkg::ByteWidth-1:0] prev_data_i,
  input  logic                          prev_valid_i,
  input  logic [cdq_pkg::ByteWidth-1:0] next_data_i,
  input  logic                          next_valid_i,
  output logic [cdq_pkg::ByteWidth-1:0] data_o,
  output logic                          valid_o,
  output logic                          last_o
);

  logic [cdq_pkg::ByteWidth-1:0] data_q, data_d;
  logic                          valid_q, valid_d;

  always_comb begin
    data_d  = data_q;
    valid_d = valid_q;
    if (cmd_i.push_front) begin
      // shift toward the rear
      data_d  = prev_data_i;
      valid_d = prev_valid_i;
    end else if (cmd_i.pop_front) begin
      // shift toward the front
      data_d  = next_data_i;
      valid_d = next_valid_i;
    end else if (cmd_i.push_rear) begin
      if (!valid_q && prev_valid_i) begin
        data_d  = cmd_i.value;
        valid_d = 1'b1;
      end
    end else if (cmd_i.pop_rear) begin
      if (valid_q && !next_valid_i) begin
        valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o  = data_q;
  assign valid_o = valid_q;
  assign last_o  = valid_q && !next_valid_i;

endmodule

// ----- rtl/circular_deque_core.sv -----
// Channel | Dir | Fields                                   | Handshake
// req_i   | in  | func[2:0], value[7:0]                    | valid/ready
// rsp_o   | out | data_out[7:0], status[1:0], now_empty,   | valid/ready
//         |     | now_full                                 |
//
// One request per clock while rsp_o.ready is high; the response follows next cycle.
// The deque is a chain of DEPTH-1 byte cells, front at cell 0; each push or pop moves
// the whole chain by one cell or changes the single rear-boundary cell in that cycle.
// Reset empties the deque at once; no clearing pass.
// A stalled response holds its register; a new request is taken in the cycle the
// response leaves, so rsp_o.ready low with a response pending stalls req_i.
module circular_deque_core #(
  parameter int unsigned DEPTH = cdq_pkg::DepthDefault
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  cdq_req_if.sink  req_i,
  cdq_rsp_if.source rsp_o
);

  localparam int unsigned NCell = DEPTH - 1;
  localparam int unsigned BW    = cdq_pkg::ByteWidth;

  cdq_pkg::cdq_cell_cmd_t cmd;
  logic [BW-1:0]          cell_data [NCell];
  logic [NCell-1:0]       cell_valid;
  logic [NCell-1:0]       cell_last;
  logic [NCell:0]         valid_hi;   // valid with an empty cell past the rear
  logic [NCell:0]         valid_lo;   // valid with a filled slot before the front
  logic                   ring_empty, is_full, in_fire;
  logic [BW-1:0]          front_data, rear_data;

  logic [BW-1:0]                  res_data;
  cdq_pkg::cdq_status_e           res_status;
  logic                           res_empty, res_full;

  logic                           rsp_valid_q, rsp_valid_d;
  logic [BW-1:0]                  rsp_data_q;
  cdq_pkg::cdq_status_e           rsp_status_q;
  logic                           rsp_empty_q, rsp_full_q;

  assign valid_hi   = {1'b0, cell_valid};
  assign valid_lo   = {cell_valid, 1'b1};
  assign ring_empty = !cell_valid[0];
  assign is_full    = cell_valid[NCell-1];
  assign front_data = cell_data[0];

  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign in_fire     = req_i.valid && req_i.ready;

  // one-hot select of the rear cell
  always_comb begin
    rear_data = '0;
    for (int i = 0; i < NCell; i++) begin
      rear_data = rear_data | (cell_data[i] & {BW{cell_last[i]}});
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.value  = req_i.value;
    res_data   = '0;
    res_status = cdq_pkg::STAT_OK;
    res_empty  = ring_empty;
    res_full   = is_full;
    case (req_i.func)
      cdq_pkg::FUNC_PUSH_REAR, cdq_pkg::FUNC_PUSH_FRONT: begin
        if (is_full) begin
          res_status = cdq_pkg::STAT_FULL;
        end else begin
          cmd.push_rear  = in_fire && (req_i.func == cdq_pkg::FUNC_PUSH_REAR);
          cmd.push_front = in_fire && (req_i.func == cdq_pkg::FUNC_PUSH_FRONT);
          res_empty      = 1'b0;
          res_full       = valid_lo[NCell-1];
        end
      end
      cdq_pkg::FUNC_POP_FRONT, cdq_pkg::FUNC_POP_REAR: begin
        if (ring_empty) begin
          res_status = cdq_pkg::STAT_EMPTY;
        end else begin
          cmd.pop_front = in_fire && (req_i.func == cdq_pkg::FUNC_POP_FRONT);
          cmd.pop_rear  = in_fire && (req_i.func == cdq_pkg::FUNC_POP_REAR);
          res_data      = (req_i.func == cdq_pkg::FUNC_POP_FRONT) ? front_data : rear_data;
          res_empty     = !valid_hi[1];
          res_full      = 1'b0;
        end
      end
      cdq_pkg::FUNC_PEEK_FRONT: begin
        if (ring_empty) begin
          res_status = cdq_pkg::STAT_EMPTY;
        end else begin
          res_data = front_data;
        end
      end
      cdq_pkg::FUNC_PEEK_REAR: begin
        if (ring_empty) begin
          res_status = cdq_pkg::STAT_EMPTY;
        end else begin
          res_data = rear_data;
        end
      end
      default: begin
        // unused code: report state, change nothing
      end
    endcase
  end

  for (genvar g = 0; g < NCell; g++) begin : g_cell
    logic [BW-1:0] prev_data, next_data;
    logic          prev_valid, next_valid;

    if (g == 0) begin : g_head
      assign prev_data  = req_i.value;
      assign prev_valid = 1'b1;
    end else begin : g_mid
      assign prev_data  = cell_data[g-1];
      assign prev_valid = cell_valid[g-1];
    end

    if (g == NCell - 1) begin : g_tail
      assign next_data  = '0;
      assign next_valid = 1'b0;
    end else begin : g_body
      assign next_data  = cell_data[g+1];
      assign next_valid = cell_valid[g+1];
    end

    cdq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .prev_data_i  (prev_data),
      .prev_valid_i (prev_valid),
      .next_data_i  (next_data),
      .next_valid_i (next_valid),
      .data_o       (cell_data[g]),
      .valid_o      (cell_valid[g]),
      .last_o       (cell_last[g])
    );
  end

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (in_fire) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // hold the result until the transaction completes
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rsp_data_q   <= res_data;
      rsp_status_q <= res_status;
      rsp_empty_q  <= res_empty;
      rsp_full_q   <= res_full;
    end
  end

  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.data_out  = rsp_data_q;
  assign rsp_o.status    = rsp_status_q;
  assign rsp_o.now_empty = rsp_empty_q;
  assign rsp_o.now_full  = rsp_full_q;

endmodule
